>>> design/fdsf_pkg.sv
package fdsf_pkg;

    localparam logic [15:0] ESCAPE_WORD = 16'hFFFF;

    typedef enum logic [2:0] {
        CFG_DESIRED_TILE   = 3'd0,
        CFG_TILE_MASK      = 3'd1,
        CFG_WINDOW_FIRST   = 3'd2,
        CFG_WINDOW_LAST    = 3'd3,
        CFG_START_POSITION = 3'd4,
        CFG_START_INDEX    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_FRAG = 2'd0,
        ST_PAST = 2'd1,
        ST_END  = 2'd2
    } t_status;

    // escape decoder phases
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HIGH = 4'b0010,
        PH_MID  = 4'b0100,
        PH_LOW  = 4'b1000
    } t_phase;

    // decoded record passed from decoder to filter (position travels apart)
    typedef struct packed {
        logic        is_end;
        logic [15:0] len;
        logic [15:0] tile;
        logic [31:0] number;
    } t_rec;

    // filter settings
    typedef struct packed {
        logic [15:0] desired_tile;
        logic [15:0] tile_mask;
        logic [47:0] window_first;
        logic [47:0] window_last;
    } t_win;

    typedef struct packed {
        t_status     status;
        logic [47:0] start;
        logic [15:0] len;
        logic [31:0] number;
        logic [15:0] tile;
    } t_res;

endpackage

>>> design/fdsf_decode.sv
module fdsf_decode #(
    parameter int POS_WIDTH = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  fdsf_pkg::t_cfg_idx     i_cfg_addr,
    input  logic [47:0]            i_cfg_data,
    input  logic                   i_valid,
    input  logic [15:0]            i_word,
    input  logic [15:0]            i_len,
    input  logic [15:0]            i_tile,
    input  logic                   i_end,
    output logic                   o_ready,
    output logic                   o_valid,
    output fdsf_pkg::t_rec         o_rec,
    output logic [POS_WIDTH-1:0]   o_pos,
    input  logic                   i_ready
);
    import fdsf_pkg::*;

    localparam int SW = ((POS_WIDTH > 48) ? POS_WIDTH : 48) + 1;

    // input register
    logic                 r_in_v;
    logic [15:0]          r_word;
    logic [15:0]          r_len;
    logic [15:0]          r_tile;
    logic                 r_end;

    // decoder state
    logic [POS_WIDTH-1:0] r_acc;
    logic [31:0]          r_cnt;
    t_phase               r_phase;
    logic [31:0]          r_hi;
    logic [15:0]          r_hlen;
    logic [15:0]          r_htile;

    // decoded register
    logic                 r_mid_v;
    t_rec                 r_rec;
    logic [POS_WIDTH-1:0] r_pos;

    logic                 en_mid;
    logic                 take;
    logic                 n_emit;
    t_phase               n_phase;
    logic [47:0]          delta;
    logic [15:0]          rec_len;
    logic [15:0]          rec_tile;
    logic [SW-1:0]        sum;
    logic [POS_WIDTH-1:0] n_acc;
    logic [31:0]          n_cnt;
    logic [SW-1:0]        cfg_ext;
    logic [POS_WIDTH-1:0] cfg_pos;

    assign en_mid  = !r_mid_v || i_ready;
    assign take    = r_in_v && en_mid;
    assign o_ready = !r_in_v || en_mid;
    assign o_valid = r_mid_v;
    assign o_rec   = r_rec;
    assign o_pos   = r_pos;

    always_comb begin
        n_emit   = 1'b0;
        n_phase  = r_phase;
        delta    = 48'(r_word);
        rec_len  = r_len;
        rec_tile = r_tile;
        if (r_end) begin
            n_emit  = 1'b1;
            n_phase = PH_IDLE;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (r_word != ESCAPE_WORD) begin
                        n_emit = 1'b1;
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end
                PH_HIGH: n_phase = PH_MID;
                PH_MID:  n_phase = PH_LOW;
                PH_LOW: begin
                    n_emit   = 1'b1;
                    n_phase  = PH_IDLE;
                    delta    = {r_hi, r_word};
                    rec_len  = r_hlen;
                    rec_tile = r_htile;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // saturating position add and fragment count
    assign sum   = SW'(r_acc) + SW'(delta);
    assign n_acc = (|sum[SW-1:POS_WIDTH]) ? {POS_WIDTH{1'b1}} : sum[POS_WIDTH-1:0];
    assign n_cnt = (r_cnt != 32'hFFFF_FFFF) ? r_cnt + 32'd1 : r_cnt;

    assign cfg_ext = SW'(i_cfg_data);
    assign cfg_pos = (|cfg_ext[SW-1:POS_WIDTH]) ? {POS_WIDTH{1'b1}}
                                                 : cfg_ext[POS_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_phase <= PH_IDLE;
            r_hi    <= '0;
            r_hlen  <= '0;
            r_htile <= '0;
        end else begin
            if (o_ready) begin
                r_in_v <= i_valid;
            end
            if (en_mid) begin
                r_mid_v <= take && n_emit;
            end
            if (take) begin
                r_phase <= n_phase;
                if (!r_end) begin
                    case (r_phase)
                        PH_IDLE: begin
                            if (r_word == ESCAPE_WORD) begin
                                r_hlen  <= r_len;
                                r_htile <= r_tile;
                            end else begin
                                r_acc <= n_acc;
                                r_cnt <= n_cnt;
                            end
                        end
                        PH_HIGH: r_hi <= {r_word, 16'h0000};
                        PH_MID:  r_hi <= {r_hi[31:16], r_word};
                        PH_LOW: begin
                            r_acc <= n_acc;
                            r_cnt <= n_cnt;
                        end
                        default: ;
                    endcase
                end
            end else if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_START_POSITION: r_acc <= cfg_pos;
                    CFG_START_INDEX:    r_cnt <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
            r_len  <= i_len;
            r_tile <= i_tile;
            r_end  <= i_end;
        end
        if (take && n_emit) begin
            r_rec.is_end <= r_end;
            r_rec.len    <= rec_len;
            r_rec.tile   <= rec_tile;
            r_rec.number <= r_cnt;
            r_pos        <= n_acc;
        end
    end

endmodule

>>> design/fdsf_filter.sv
module fdsf_filter #(
    parameter int POS_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fdsf_pkg::t_win       i_win,
    input  logic                 i_valid,
    input  fdsf_pkg::t_rec       i_rec,
    input  logic [POS_WIDTH-1:0] i_pos,
    output logic                 o_ready,
    output logic                 o_valid,
    output fdsf_pkg::t_res       o_res,
    input  logic                 i_ready
);
    import fdsf_pkg::*;

    localparam int CW = ((POS_WIDTH > 48) ? POS_WIDTH : 48) + 1;

    logic          r_out_v;
    t_res          r_res;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] end_x;
    logic [CW-1:0] first_x;
    logic          tile_miss;
    logic          before_win;
    logic          past_end;
    logic          keep;
    t_res          n_res;

    assign o_ready = !r_out_v || i_ready;
    assign o_valid = r_out_v;
    assign o_res   = r_res;

    assign pos_x      = CW'(i_pos);
    assign first_x    = CW'(i_win.window_first);
    assign end_x      = pos_x + CW'(i_rec.len);
    assign tile_miss  = (i_rec.tile & i_win.tile_mask) != i_win.desired_tile;
    // dropped when it starts before the window and ends at or before the window start
    assign before_win = (pos_x < first_x) && (end_x <= first_x);
    assign past_end   = pos_x > CW'(i_win.window_last);
    assign keep       = i_rec.is_end || (!tile_miss && !before_win);

    always_comb begin
        n_res = '0;
        if (i_rec.is_end) begin
            n_res.status = ST_END;
        end else if (past_end) begin
            n_res.status = ST_PAST;
        end else begin
            n_res.status = ST_FRAG;
            n_res.start  = 48'(i_pos);
            n_res.len    = i_rec.len;
            n_res.number = i_rec.number;
            n_res.tile   = i_rec.tile;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (o_ready) begin
            r_out_v <= i_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && keep) begin
            r_res <= n_res;
        end
    end

endmodule

>>> design/fragment_delta_stream_filter.sv
// Delta-coded fragment position decoder and window/tile filter.
// Slave channel: one 16-bit position word per request, with the record's
// length and tile (sampled on the record's first word) and a stream-end
// flag in tuser. The word 0xFFFF escapes: the next three words carry a
// 48-bit delta, high word first. Each record advances the saturating
// position and fragment counters.
// Master channel: one result per kept record or stream end; tuser holds the
// status (fragment, past window end, stream ended).
// Throughput: one word per cycle while the receiver keeps up. The path is
// input register, decode register (position add), result register (window
// and tile compares), which drives the master channel.
// Each stage loads whenever it is empty or the next stage takes its
// contents, so bubbles are squeezed out and a stalled receiver only stops
// the input after all three registers are full.
// Reset clears the pipeline, the escape state and the counters, and loads
// the registers with their defaults (window end all ones). Configuration
// writes must be issued only while the pipeline is empty; writing the start
// position or start index also loads the position or fragment counter.
module fragment_delta_stream_filter #(
    parameter int POS_WIDTH = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  fdsf_pkg::t_cfg_idx  i_cfg_addr,
    input  logic [47:0]         i_cfg_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [47:0]         i_s_tdata,   // pos_word, frag_length, frag_tile
    input  logic                i_s_tuser,   // stream_end
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [111:0]        o_m_tdata,   // frag_start, frag_length_out,
                                             // frag_number, frag_tile_out
    output logic [1:0]          o_m_tuser    // status
);
    import fdsf_pkg::*;

    t_win                 r_win;
    logic                 mid_valid;
    logic                 mid_ready;
    t_rec                 mid_rec;
    logic [POS_WIDTH-1:0] mid_pos;
    t_res                 res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.desired_tile <= '0;
            r_win.tile_mask    <= '0;
            r_win.window_first <= '0;
            r_win.window_last  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DESIRED_TILE: r_win.desired_tile <= i_cfg_data[15:0];
                CFG_TILE_MASK:    r_win.tile_mask    <= i_cfg_data[15:0];
                CFG_WINDOW_FIRST: r_win.window_first <= i_cfg_data;
                CFG_WINDOW_LAST:  r_win.window_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fdsf_decode #(
        .POS_WIDTH (POS_WIDTH)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .i_word     (i_s_tdata[15:0]),
        .i_len      (i_s_tdata[31:16]),
        .i_tile     (i_s_tdata[47:32]),
        .i_end      (i_s_tuser),
        .o_ready    (o_s_tready),
        .o_valid    (mid_valid),
        .o_rec      (mid_rec),
        .o_pos      (mid_pos),
        .i_ready    (mid_ready)
    );

    fdsf_filter #(
        .POS_WIDTH (POS_WIDTH)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_win),
        .i_valid (mid_valid),
        .i_rec   (mid_rec),
        .i_pos   (mid_pos),
        .o_ready (mid_ready),
        .o_valid (o_m_tvalid),
        .o_res   (res),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {res.tile, res.number, res.len, res.start};
    assign o_m_tuser = res.status;

endmodule

>>> verif/fragment_delta_stream_filter_tb.sv
`timescale 1ns / 100ps

module fragment_delta_stream_filter_tb;
    import fdsf_pkg::*;

    localparam logic [47:0] POS_MAX      = 48'hFFFF_FFFF_FFFF;
    localparam int          IDLE_PCT     = 16;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASE_WORDS  = 300;
    localparam int          MAX_REPORTS  = 10;

    // one request on the word channel
    typedef struct packed {
        logic        eos;
        logic [15:0] tile;
        logic [15:0] len;
        logic [15:0] word;
    } t_word_req;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    t_cfg_idx     cfg_addr = CFG_DESIRED_TILE;
    logic [47:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;

    fragment_delta_stream_filter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    t_word_req src_words[$];
    t_res      due_results[$];
    int        error_cnt = 0;

    // decoder mirror
    logic [47:0] acc_pos;
    logic [31:0] frag_cnt;
    t_phase      esc_phase;
    logic [31:0] esc_hi;
    logic [15:0] hold_len;
    logic [15:0] hold_tile;
    logic [15:0] want_tile;
    logic [15:0] tile_mask;
    logic [47:0] win_first;
    logic [47:0] win_last;

    logic      s_fire = 1'b0;
    logic      calm = 1'b0;
    logic      hold_req = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_cnt = 0;
    t_word_req nxt;

    task automatic close_record(input logic [47:0] delta, input logic [15:0] len,
                                input logic [15:0] tile);
        logic [48:0] sum;
        logic [31:0] number;
        t_res        res;
        sum = {1'b0, acc_pos} + {1'b0, delta};
        number = frag_cnt;
        acc_pos = sum[48] ? POS_MAX : sum[47:0];
        if (frag_cnt != 32'hFFFF_FFFF) frag_cnt = frag_cnt + 32'd1;
        res = '0;
        if ((tile & tile_mask) != want_tile) return;
        // fragment ends at or before the window start
        if (acc_pos < win_first && {32'd0, len} <= win_first - acc_pos) return;
        if (acc_pos > win_last) begin
            res.status = ST_PAST;
        end else begin
            res.status = ST_FRAG;
            res.start  = acc_pos;
            res.len    = len;
            res.number = number;
            res.tile   = tile;
        end
        due_results.push_back(res);
    endtask

    task automatic advance_decoder(input t_word_req r);
        t_res res;
        res = '0;
        if (r.eos) begin
            // a partial escape is abandoned
            esc_phase = PH_IDLE;
            res.status = ST_END;
            due_results.push_back(res);
        end else begin
            case (esc_phase)
                PH_IDLE: begin
                    if (r.word != ESCAPE_WORD) begin
                        close_record({32'd0, r.word}, r.len, r.tile);
                    end else begin
                        hold_len  = r.len;
                        hold_tile = r.tile;
                        esc_phase = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    esc_hi    = {r.word, 16'd0};
                    esc_phase = PH_MID;
                end
                PH_MID: begin
                    esc_hi[15:0] = r.word;
                    esc_phase    = PH_LOW;
                end
                default: begin
                    close_record({esc_hi, r.word}, hold_len, hold_tile);
                    esc_phase = PH_IDLE;
                end
            endcase
        end
    endtask

    // word channel driver
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (src_words.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = src_words.pop_front();
                s_tdata  <= {nxt.tile, nxt.len, nxt.word};
                s_tuser  <= nxt.eos;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result channel receiver, with one long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // monitor: predict on accepted words, check accepted results
    always @(posedge clk) begin
        t_res got;
        t_res want;
        s_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                advance_decoder({s_tuser, s_tdata[47:32], s_tdata[31:16], s_tdata[15:0]});
            if (m_tvalid && m_tready) begin
                got.status = t_status'(m_tuser);
                got.start  = m_tdata[47:0];
                got.len    = m_tdata[63:48];
                got.number = m_tdata[95:64];
                got.tile   = m_tdata[111:96];
                if (due_results.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("unexpected result: status %0d start %h", m_tuser, got.start);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.start !== want.start ||
                        got.len !== want.len || got.number !== want.number ||
                        got.tile !== want.tile) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS) begin
                            $display("mismatch: exp st %0d start %h len %h num %h tile %h",
                                     want.status, want.start, want.len, want.number,
                                     want.tile);
                            $display("          got st %0d start %h len %h num %h tile %h",
                                     got.status, got.start, got.len, got.number,
                                     got.tile);
                        end
                    end
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DESIRED_TILE:   want_tile = val[15:0];
            CFG_TILE_MASK:      tile_mask = val[15:0];
            CFG_WINDOW_FIRST:   win_first = val;
            CFG_WINDOW_LAST:    win_last  = val;
            CFG_START_POSITION: acc_pos   = val;
            default:            frag_cnt  = val[31:0];
        endcase
    endtask

    task automatic program_filter(input logic [15:0] desired, input logic [15:0] mask,
                                  input logic [47:0] wf, input logic [47:0] wl,
                                  input logic [47:0] sp, input logic [31:0] si);
        write_reg(CFG_DESIRED_TILE, {32'd0, desired});
        write_reg(CFG_TILE_MASK, {32'd0, mask});
        write_reg(CFG_WINDOW_FIRST, wf);
        write_reg(CFG_WINDOW_LAST, wl);
        write_reg(CFG_START_POSITION, sp);
        write_reg(CFG_START_INDEX, {16'd0, si});
    endtask

    // wait for every word taken and every result seen, then let the pipe empty
    task automatic drain();
        while (src_words.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic push_word(input logic [15:0] word, input logic [15:0] len,
                             input logic [15:0] tile);
        src_words.push_back({1'b0, tile, len, word});
    endtask

    function automatic logic [15:0] rnd_len();
        return $urandom_range(0, 1) ? 16'($urandom_range(0, 64)) : 16'($urandom);
    endfunction

    // about half the tiles are steered to match the filter
    function automatic logic [15:0] pick_tile();
        logic [15:0] t;
        t = 16'($urandom);
        if ($urandom_range(0, 1)) t = (want_tile & tile_mask) | (t & ~tile_mask);
        return t;
    endfunction

    task automatic queue_random_record(input bit wide, output int n);
        int          r;
        int          k;
        logic [15:0] hi;
        logic [15:0] mid;
        r = $urandom_range(0, 99);
        n = 0;
        if (r < 4) begin
            src_words.push_back({1'b1, 16'($urandom), 16'($urandom), 16'($urandom)});
            n = 1;
        end else if (r < 8) begin
            // broken escape cut off by stream end
            push_word(ESCAPE_WORD, rnd_len(), pick_tile());
            k = $urandom_range(0, 2);
            repeat (k) push_word(16'($urandom), 16'($urandom), 16'($urandom));
            src_words.push_back({1'b1, 16'($urandom), 16'($urandom), 16'($urandom)});
            n = k + 2;
        end else if (r < 28) begin
            hi  = wide ? 16'($urandom) : ($urandom_range(0, 9) == 0 ? 16'd1 : 16'd0);
            mid = ($urandom_range(0, 19) == 0 || wide) ? 16'($urandom) : 16'd0;
            push_word(ESCAPE_WORD, rnd_len(), pick_tile());
            push_word(hi, 16'($urandom), 16'($urandom));
            push_word(mid, 16'($urandom), 16'($urandom));
            push_word(16'($urandom), 16'($urandom), 16'($urandom));
            n = 4;
        end else begin
            push_word($urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                           : 16'($urandom_range(0, 16'hFFFE)),
                      rnd_len(), pick_tile());
            n = 1;
        end
    endtask

    initial begin
        int          ph;
        int          n;
        int          cnt;
        logic [15:0] mask;
        logic [47:0] sp;
        logic [47:0] wf;
        logic [47:0] wl;
        bit          wide;

        want_tile = '0;
        tile_mask = '0;
        win_first = '0;
        win_last  = POS_MAX;
        acc_pos   = '0;
        frag_cnt  = '0;
        esc_phase = PH_IDLE;
        esc_hi    = '0;
        hold_len  = '0;
        hold_tile = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: everything passes the filter
        push_word(16'd0, 16'd0, 16'd0);
        push_word(16'd1, 16'hFFFF, 16'hFFFF);
        push_word(16'hFFFE, 16'h1234, 16'hA5A5);
        push_word(ESCAPE_WORD, 16'd7, 16'd3);
        push_word(16'd0, 16'hFFFF, 16'hFFFF);
        push_word(16'd0, 16'd0, 16'd0);
        push_word(16'd5, 16'd0, 16'd0);
        src_words.push_back({1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        src_words.push_back({1'b1, 16'd0, 16'd0, 16'd0});
        push_word(ESCAPE_WORD, 16'd9, 16'd9);
        push_word(16'd1, 16'd0, 16'd0);
        src_words.push_back({1'b1, 16'd0, 16'd0, ESCAPE_WORD});
        // largest escaped delta saturates the position
        push_word(ESCAPE_WORD, 16'd2, 16'd4);
        push_word(ESCAPE_WORD, 16'd0, 16'd0);
        push_word(ESCAPE_WORD, 16'd0, 16'd0);
        push_word(ESCAPE_WORD, 16'd0, 16'd0);
        push_word(16'd10, 16'd1, 16'd1);
        drain();

        // window edges, tile drop, past end, counter saturation
        program_filter(16'd5, 16'h000F, 48'd2000, 48'd3000, 48'd1000, 32'hFFFF_FFFE);
        push_word(16'd500, 16'd0, 16'h0005);
        push_word(16'd400, 16'd100, 16'h0015);
        push_word(16'd50, 16'd100, 16'h0025);
        push_word(16'd50, 16'd8, 16'h0006);
        push_word(16'd0, 16'd0, 16'h0005);
        push_word(16'd1001, 16'd3, 16'h0005);
        push_word(16'd0, 16'd3, 16'hFFF5);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            sp   = {16'd0, 32'($urandom)};
            wf   = sp + 48'($urandom_range(0, 1 << 20));
            wl   = wf + 48'($urandom_range(0, 1 << 23));
            mask = 16'($urandom);
            wide = 1'b0;
            case (ph)
                0: program_filter(16'd0, 16'd0, 48'd0, POS_MAX, sp, 32'($urandom));
                1: program_filter(16'($urandom), 16'hFFFF, 48'd0, 48'd0, 48'd0, 32'd0);
                2: begin
                    program_filter(16'($urandom) & 16'h000F, 16'h000F, wf, wl, sp,
                                   32'($urandom));
                    hold_req = 1'b1;
                end
                3: begin
                    program_filter(16'($urandom) & mask, mask, wf, wl, sp, 32'hFFFF_FFF0);
                    calm = 1'b1;
                end
                4: begin
                    wide = 1'b1;
                    program_filter(16'hFFFF, 16'hFFFF, POS_MAX, POS_MAX,
                                   POS_MAX - 48'($urandom_range(0, 1 << 20)), 32'($urandom));
                end
                default: program_filter(16'($urandom) & mask, mask, wf, wl, sp, 32'($urandom));
            endcase
            cnt = 0;
            while (cnt < PHASE_WORDS) begin
                queue_random_record(wide, n);
                cnt += n;
            end
            drain();
            calm = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_cnt == 0 && due_results.size() == 0) begin
            $display("fragment_delta_stream_filter_tb: clean");
        end else begin
            $display("fragment_delta_stream_filter_tb: errors");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("fragment_delta_stream_filter_tb: errors");
        $finish;
    end

endmodule
